[hw/rtl/jofr_pkg.sv]
// Shared types and character constants for the JSON object frame recognizer.
package jofr_pkg;

  // Delimiter and separator characters.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Command codes carried in the input tuser.
  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // What the rule table does with a character.
  typedef enum logic [1:0] {
    ACT_DROP  = 2'd0,
    ACT_FLUSH = 2'd1,
    ACT_TAKE  = 2'd2
  } action_t;

  // Stack operation that goes with an appended character.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_REPL = 2'd2,
    OP_POP  = 2'd3
  } stack_op_t;

  // Occupancy flags that the rules look at, after any armed flush.
  typedef struct packed {
    logic has_top;
    logic lvl_gt1;
    logic cnt_zero;
    logic cnt_one;
  } rule_ctx_t;

  // Decision handed back to the state update.
  typedef struct packed {
    action_t   act;
    stack_op_t op;
  } rule_dec_t;

endpackage

[hw/rtl/jofr_ram.sv]
// Synchronous single-write, single-read memory with a registered read and write forwarding.
module jofr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] fwd_data;
  logic             fwd_hit;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a same-address write in the read cycle is forwarded.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_q     <= mem[raddr];
      fwd_hit  <= we && (waddr == raddr);
      fwd_data <= wdata;
    end
  end

  assign rdata = fwd_hit ? fwd_data : rd_q;

endmodule

[hw/rtl/jofr_rule_decode.sv]
// Ordered rule table that picks drop, flush or append with a stack operation.
module jofr_rule_decode (
  input  logic [7:0]          ch,
  input  logic [7:0]          top,
  input  jofr_pkg::rule_ctx_t ctx,
  output jofr_pkg::rule_dec_t dec
);

  logic top_quote;

  assign top_quote = (top == jofr_pkg::CH_QUOTE);

  // The first matching rule wins.
  always_comb begin
    dec.act = jofr_pkg::ACT_DROP;
    dec.op  = jofr_pkg::OP_NONE;
    if (ctx.lvl_gt1 && !ctx.cnt_zero && !top_quote && ch == jofr_pkg::CH_SPACE) begin
      dec.act = jofr_pkg::ACT_DROP;
    end else if (ctx.cnt_zero && ch == jofr_pkg::CH_LBRACE) begin
      dec.act = jofr_pkg::ACT_TAKE;
      dec.op  = jofr_pkg::OP_PUSH;
    end else if (ctx.cnt_one && ch == jofr_pkg::CH_QUOTE) begin
      dec.act = jofr_pkg::ACT_TAKE;
      dec.op  = jofr_pkg::OP_PUSH;
    end else if (ctx.cnt_one) begin
      dec.act = jofr_pkg::ACT_FLUSH;
    end else if (!ctx.has_top) begin
      dec.act = jofr_pkg::ACT_DROP;
    end else if (top == jofr_pkg::CH_LBRACK && ch != jofr_pkg::CH_QUOTE) begin
      // A closing bracket on an open bracket lands here as well.
      dec.act = jofr_pkg::ACT_FLUSH;
    end else if (top == jofr_pkg::CH_COLON) begin
      if (ch == jofr_pkg::CH_QUOTE || ch == jofr_pkg::CH_LBRACK ||
          ch == jofr_pkg::CH_LBRACE) begin
        dec.act = jofr_pkg::ACT_TAKE;
        dec.op  = jofr_pkg::OP_REPL;
      end else begin
        dec.act = jofr_pkg::ACT_FLUSH;
      end
    end else if (top == jofr_pkg::CH_COMMA) begin
      if (ch == jofr_pkg::CH_QUOTE) begin
        dec.act = jofr_pkg::ACT_TAKE;
        dec.op  = jofr_pkg::OP_REPL;
      end else begin
        dec.act = jofr_pkg::ACT_FLUSH;
      end
    end else if ((ch == jofr_pkg::CH_LBRACE || ch == jofr_pkg::CH_COLON ||
                  ch == jofr_pkg::CH_COMMA) && !top_quote) begin
      dec.act = jofr_pkg::ACT_TAKE;
      dec.op  = jofr_pkg::OP_PUSH;
    end else if (top_quote) begin
      dec.act = jofr_pkg::ACT_TAKE;
      dec.op  = (ch == jofr_pkg::CH_QUOTE) ? jofr_pkg::OP_POP : jofr_pkg::OP_NONE;
    end else if (ch == jofr_pkg::CH_QUOTE) begin
      dec.act = jofr_pkg::ACT_TAKE;
      dec.op  = jofr_pkg::OP_PUSH;
    end else if (top == jofr_pkg::CH_LBRACE) begin
      dec.act = jofr_pkg::ACT_TAKE;
      dec.op  = (ch == jofr_pkg::CH_RBRACE) ? jofr_pkg::OP_POP : jofr_pkg::OP_NONE;
    end
  end

endmodule

[hw/rtl/json_object_frame_recognizer.sv]
// Top level of the JSON object frame recognizer: state update, memories and output register.
// A result is registered as its input transaction is accepted and is presented in the next cycle.
// Throughput: one transaction per cycle while the output is free; the stack RAM is read every cycle
// at the new top address, with write forwarding, so the next character always sees the current top.
// The character buffer RAM is written by feeds and read once per read command.
// Reset (synchronous, rst high) empties the buffer and stack and drops the output; no clearing pass.
module json_object_frame_recognizer #(
  parameter int STACK_DEPTH = 64,
  parameter int BUF_DEPTH   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] char_in, [15:8] read_index
  input  logic [0:0]  s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [0] frame_valid, [9:1] frame_length, [17:10] read_data, zero fill
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int BAW   = $clog2(BUF_DEPTH);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  logic             s_fire;
  logic             is_read;
  logic [7:0]       ch;
  logic [7:0]       rd_idx;

  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] level_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             clear_pending;
  logic             clear_pending_next;

  logic [LVL_W-1:0] lvl_e;
  logic [CNT_W-1:0] cnt_e;
  logic             buf_full;
  logic             stk_full;
  logic             in_range;

  jofr_pkg::rule_ctx_t ctx;
  jofr_pkg::rule_dec_t dec;

  logic             stk_we;
  logic [SAW-1:0]   stk_wa;
  logic [SAW-1:0]   stk_ra;
  logic [7:0]       stk_top;
  logic             buf_we;
  logic [7:0]       buf_rd;

  logic             fv_q;
  logic [8:0]       len_q;
  logic             zero_q;

  // Input unpacking and handshake.
  assign s_fire   = s_tvalid && s_tready;
  assign is_read  = (s_tuser[0] == jofr_pkg::CMD_READ);
  assign ch       = s_tdata[7:0];
  assign rd_idx   = s_tdata[15:8];
  assign s_tready = !m_tvalid || m_tready;

  // Occupancy as the rules see it, after an armed flush.
  assign lvl_e        = clear_pending ? '0 : level;
  assign cnt_e        = clear_pending ? '0 : count;
  assign ctx.has_top  = (lvl_e != '0);
  assign ctx.lvl_gt1  = (lvl_e > LVL_W'(1));
  assign ctx.cnt_zero = (cnt_e == '0);
  assign ctx.cnt_one  = (cnt_e == CNT_W'(1));
  assign buf_full     = (cnt_e == CNT_W'(BUF_DEPTH));
  assign stk_full     = (lvl_e == LVL_W'(STACK_DEPTH));

  jofr_rule_decode u_rules (
    .ch  (ch),
    .top (stk_top),
    .ctx (ctx),
    .dec (dec)
  );

  // Next state and memory writes for the accepted transaction.
  always_comb begin
    level_next         = level;
    count_next         = count;
    clear_pending_next = clear_pending;
    stk_we             = 1'b0;
    stk_wa             = SAW'(lvl_e);
    buf_we             = 1'b0;
    if (s_fire) begin
      if (is_read) begin
        clear_pending_next = 1'b1;
      end else begin
        clear_pending_next = 1'b0;
        level_next         = lvl_e;
        count_next         = cnt_e;
        case (dec.act)
          jofr_pkg::ACT_FLUSH: begin
            level_next = '0;
            count_next = '0;
          end
          jofr_pkg::ACT_TAKE: begin
            if (buf_full || (dec.op == jofr_pkg::OP_PUSH && stk_full)) begin
              // Overflow of either store flushes instead of appending.
              level_next = '0;
              count_next = '0;
            end else begin
              buf_we     = 1'b1;
              count_next = cnt_e + CNT_W'(1);
              case (dec.op)
                jofr_pkg::OP_PUSH: begin
                  stk_we     = 1'b1;
                  stk_wa     = SAW'(lvl_e);
                  level_next = lvl_e + LVL_W'(1);
                end
                jofr_pkg::OP_REPL: begin
                  stk_we = 1'b1;
                  stk_wa = SAW'(lvl_e - LVL_W'(1));
                end
                jofr_pkg::OP_POP: begin
                  level_next = lvl_e - LVL_W'(1);
                end
                default: begin
                end
              endcase
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The stack RAM is read every cycle at the top of the updated stack.
  assign stk_ra = SAW'(level_next - LVL_W'(1));

  jofr_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (8)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_wa),
    .wdata (ch),
    .re    (1'b1),
    .raddr (stk_ra),
    .rdata (stk_top)
  );

  // Character buffer: appended at the fill count, read by read commands.
  jofr_ram #(
    .DEPTH (BUF_DEPTH),
    .WIDTH (8)
  ) u_char_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (BAW'(cnt_e)),
    .wdata (ch),
    .re    (s_fire && is_read),
    .raddr (BAW'(rd_idx)),
    .rdata (buf_rd)
  );

  assign in_range = (CMP_W'(rd_idx) < CMP_W'(count));

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= '0;
      count         <= '0;
      clear_pending <= 1'b0;
    end else begin
      level         <= level_next;
      count         <= count_next;
      clear_pending <= clear_pending_next;
    end
  end

  // Output register; it holds while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      fv_q   <= (count_next != '0) && (level_next == '0);
      len_q  <= 9'(count_next);
      zero_q <= !(is_read && in_range);
    end
  end

  assign m_tdata = {6'd0, (zero_q ? 8'd0 : buf_rd), len_q, fv_q};

  // Checks on internal state.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(STACK_DEPTH))
    else $error("stack level exceeds the stack depth");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(BUF_DEPTH))
    else $error("character count exceeds the buffer depth");

  a_read_arms: assert property (@(posedge clk) disable iff (rst)
    (s_fire && is_read) |=> clear_pending)
    else $error("read command did not arm the flush");

  a_valid_nonempty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[9:1] != 9'd0))
    else $error("frame reported valid with an empty buffer");

  a_feed_clears: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !is_read) |=> !clear_pending)
    else $error("armed flush survived a feed transaction");

endmodule

[bench/jofr_checker.sv]
// Checker that tracks the frame recognizer state and compares every output transaction.
module jofr_checker
  import jofr_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int BUF_DEPTH   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] char_in, [15:8] read_index
  input  logic [0:0]  s_tuser,   // [0] command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [0] frame_valid, [9:1] frame_length, [17:10] read_data
  output int          mismatch_count,
  output int          awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // One output transaction as the recognizer should present it.
  typedef struct packed {
    logic       valid;
    logic [8:0] length;
    logic [7:0] data;
  } frame_status_t;

  frame_status_t awaited_status[$];

  // Tracked copy of the delimiter stack, the character buffer and the flush flag.
  logic [7:0] delim_stk  [STACK_DEPTH];
  logic [7:0] char_store [BUF_DEPTH];
  int         stk_level;
  int         char_count;
  bit         flush_armed;
  int         bad_results = 0;

  function automatic void clear_frame();
    char_count  = 0;
    stk_level   = 0;
    flush_armed = 1'b0;
  endfunction

  // Appends a character with its stack operation; a full buffer or stack flushes instead.
  function automatic void take_char(logic [7:0] c, stack_op_t op);
    if (char_count >= BUF_DEPTH || (op == OP_PUSH && stk_level >= STACK_DEPTH)) begin
      clear_frame();
      return;
    end
    char_store[char_count] = c;
    char_count++;
    case (op)
      OP_PUSH: begin
        delim_stk[stk_level] = c;
        stk_level++;
      end
      OP_REPL: if (stk_level >= 1) delim_stk[stk_level - 1] = c;
      OP_POP:  if (stk_level >= 1) stk_level--;
      default: ;
    endcase
  endfunction

  // Ordered rule table: the first rule that matches the character and the stack top wins.
  function automatic void feed_char(logic [7:0] c);
    logic [7:0] top;
    top = (stk_level >= 1) ? delim_stk[stk_level - 1] : 8'h00;
    if (stk_level > 1 && char_count > 0 && top != CH_QUOTE && c == CH_SPACE) return;
    if (char_count == 0 && c == CH_LBRACE) begin
      take_char(c, OP_PUSH);
      return;
    end
    if (char_count == 1 && c == CH_QUOTE) begin
      take_char(c, OP_PUSH);
      return;
    end
    if (char_count == 1) begin
      clear_frame();
      return;
    end
    if (stk_level == 0) return;
    if (top == CH_LBRACK && c != CH_QUOTE) begin
      clear_frame();
      return;
    end
    if (top == CH_COLON) begin
      if (c == CH_QUOTE || c == CH_LBRACK || c == CH_LBRACE) take_char(c, OP_REPL);
      else clear_frame();
      return;
    end
    if (top == CH_COMMA) begin
      if (c == CH_QUOTE) take_char(c, OP_REPL);
      else clear_frame();
      return;
    end
    if ((c == CH_LBRACE || c == CH_COLON || c == CH_COMMA) && top != CH_QUOTE) begin
      take_char(c, OP_PUSH);
      return;
    end
    if (top == CH_QUOTE) take_char(c, (c == CH_QUOTE) ? OP_POP : OP_NONE);
    else if (c == CH_QUOTE) take_char(c, OP_PUSH);
    else if (top == CH_LBRACE) take_char(c, (c == CH_RBRACE) ? OP_POP : OP_NONE);
  endfunction

  // Applies one input transaction and returns the status it should produce.
  function automatic frame_status_t next_status(logic cmd, logic [7:0] c, logic [7:0] idx);
    frame_status_t st;
    st.data = 8'h00;
    if (cmd == CMD_FEED) begin
      if (flush_armed) clear_frame();
      feed_char(c);
    end else begin
      // A read sees the buffer as it is; the flush waits for the next character.
      if (idx < char_count) st.data = char_store[idx];
      flush_armed = 1'b1;
    end
    st.valid  = (char_count > 0 && stk_level == 0);
    st.length = char_count[8:0];
    return st;
  endfunction

  function automatic void note_failure(string msg);
    bad_results++;
    if (bad_results <= 10) $display("%t %s", $realtime, msg);
  endfunction

  // Results are compared before the new input is recorded, so a result can never
  // be matched against the transaction accepted at the same edge.
  always @(posedge clk) begin : watch
    frame_status_t seen;
    frame_status_t want;
    if (rst) begin
      clear_frame();
      awaited_status.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen = '{m_tdata[0], m_tdata[9:1], m_tdata[17:10]};
        if (awaited_status.size() == 0) begin
          note_failure($sformatf("unexpected result valid=%0d len=%0d data=%02h",
                                 seen.valid, seen.length, seen.data));
        end else begin
          want = awaited_status.pop_front();
          if (seen.valid !== want.valid || seen.length !== want.length ||
              seen.data !== want.data) begin
            note_failure($sformatf(
              "mismatch: expected valid=%0d len=%0d data=%02h, got valid=%0d len=%0d data=%02h",
              want.valid, want.length, want.data, seen.valid, seen.length, seen.data));
          end
        end
      end
      if (s_tvalid && s_tready)
        awaited_status.push_back(next_status(s_tuser[0], s_tdata[7:0], s_tdata[15:8]));
    end
    mismatch_count <= bad_results;
    awaited_count  <= awaited_status.size();
  end

endmodule

[bench/tb_json_object_frame_recognizer.sv]
// Testbench top: drives characters and reads into the frame recognizer and gives the verdict.
module tb_json_object_frame_recognizer;
  import jofr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 64;
  localparam int BUF_DEPTH   = 256;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  int          mismatch_count;
  int          awaited_count;

  // Stretches of back-to-back traffic on each side.
  int          send_calm = 0;
  int          sink_calm = 0;
  // Input transactions accepted so far, directed and random together.
  int          sent_items = 0;

  // Characters of the sequence under construction.
  logic [7:0]  frame_text[$];

  json_object_frame_recognizer #(
    .STACK_DEPTH(STACK_DEPTH),
    .BUF_DEPTH  (BUF_DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  jofr_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .BUF_DEPTH  (BUF_DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .mismatch_count(mismatch_count),
    .awaited_count (awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Wait before a transaction: a gap drawn at random, sometimes a run of no waits.
  function automatic int idle_cycles(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // A delimiter half of the time, otherwise any byte.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 15))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_LBRACK;
      3: return CH_RBRACK;
      4: return CH_COLON;
      5: return CH_COMMA;
      6: return CH_QUOTE;
      7: return CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // String content: mostly lowercase letters, never a quote.
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                    : 8'($urandom_range(8'h61, 8'h7A));
    return (c == CH_QUOTE) ? 8'h71 : c;
  endfunction

  function automatic void add_blank();
    if ($urandom_range(0, 3) == 0) frame_text.push_back(CH_SPACE);
  endfunction

  function automatic void add_string();
    frame_text.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 6)) frame_text.push_back(body_char());
    frame_text.push_back(CH_QUOTE);
  endfunction

  // Well-formed object with random keys, values, nesting and spacing.
  function automatic void add_object(int depth);
    int pairs;
    pairs = $urandom_range(0, 3);
    frame_text.push_back(CH_LBRACE);
    for (int i = 0; i < pairs; i++) begin
      if (i > 0) frame_text.push_back(CH_COMMA);
      add_string();
      add_blank();
      frame_text.push_back(CH_COLON);
      add_blank();
      case ($urandom_range(0, 5))
        0: if (depth > 0) add_object(depth - 1); else add_string();
        1: begin
          frame_text.push_back(CH_LBRACK);
          add_string();
          frame_text.push_back(CH_RBRACK);
        end
        default: add_string();
      endcase
    end
    frame_text.push_back(CH_RBRACE);
  endfunction

  // Presents one input transaction and holds it until it is accepted.
  task automatic send_transaction(logic cmd, logic [7:0] c, logic [7:0] idx);
    int gap;
    gap = idle_cycles(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {idx, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic read_byte(logic [7:0] idx);
    send_transaction(CMD_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic feed_string(string s);
    for (int i = 0; i < s.len(); i++)
      send_transaction(CMD_FEED, s[i], 8'($urandom_range(0, 255)));
  endtask

  // Feeds the built sequence, with an optional read slipped in before position read_at.
  task automatic feed_text(int read_at);
    for (int i = 0; i < frame_text.size(); i++) begin
      if (i == read_at) read_byte(8'($urandom_range(0, 255)));
      send_transaction(CMD_FEED, frame_text[i], 8'($urandom_range(0, 255)));
    end
    frame_text.delete();
  endtask

  // Stops sending until every expected result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
  endtask

  // Result side: random stalls before each output transaction.
  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = idle_cycles(sink_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int pos;
    int extra;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: read on an empty buffer, then a stray character after the armed flush.
    read_byte(8'd0);
    feed_string("a");
    // Complete object; the space after the colon is dropped, so is the one after the frame.
    feed_string("{\"a\": \"b\"}");
    feed_string(" ");
    read_byte(8'd0);
    read_byte(8'd8);
    read_byte(8'd9);
    read_byte(8'hFF);
    // Closing bracket on an open bracket flushes; so does a non-quote second character.
    feed_string("{\"k\":[]");
    feed_string("{x");
    wait_drained();

    // Buffer fill: one pass overflows, the other fills the buffer and reads from it while full.
    for (int pass = 0; pass < 2; pass++) begin
      frame_text.push_back(CH_LBRACE);
      frame_text.push_back(CH_QUOTE);
      while (frame_text.size() < BUF_DEPTH) frame_text.push_back(body_char());
      if (pass == 0) frame_text.push_back(body_char());
      feed_text(-1);
      if (pass == 1) begin
        read_byte(8'hFF);
        read_byte(8'd0);
        read_byte(8'($urandom_range(0, 255)));
      end
    end

    // Stack fill: one pass overflows, the other closes every level into a valid frame.
    for (int pass = 0; pass < 2; pass++) begin
      frame_text.push_back(CH_LBRACE);
      frame_text.push_back(CH_QUOTE);
      frame_text.push_back(CH_QUOTE);
      repeat (STACK_DEPTH - 1) frame_text.push_back(CH_LBRACE);
      if (pass == 0) frame_text.push_back(CH_LBRACE);
      else repeat (STACK_DEPTH) frame_text.push_back(CH_RBRACE);
      feed_text(-1);
      read_byte(8'($urandom_range(0, 140)));
    end
    wait_drained();

    // Random part: mostly well-formed objects followed by reads, plus broken ones and noise.
    while (sent_items < 880) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          add_object($urandom_range(0, 3));
          if ($urandom_range(0, 4) == 0) frame_text.push_back(pick_char());
          feed_text(-1);
          extra = $urandom_range(0, 3);
          repeat (extra)
            read_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 24))
                                            : 8'($urandom_range(0, 255)));
        end
        6, 7: begin
          add_object($urandom_range(0, 2));
          pos = $urandom_range(0, frame_text.size() - 1);
          case ($urandom_range(0, 2))
            0: frame_text[pos] = pick_char();
            1: begin
              while (frame_text.size() > pos + 1) void'(frame_text.pop_back());
              frame_text.push_back(pick_char());
            end
            default: ;
          endcase
          feed_text(($urandom_range(0, 2) == 0) ? pos : -1);
        end
        default: begin
          repeat ($urandom_range(1, 6))
            send_transaction($urandom_range(0, 3) == 0 ? CMD_READ : CMD_FEED, pick_char(),
                             8'($urandom_range(0, 255)));
        end
      endcase
      if ($urandom_range(0, 39) == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) $display("json_object_frame_recognizer test passed");
    else $display("json_object_frame_recognizer test failed");
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin : watchdog
    #(5_000_000);
    $display("json_object_frame_recognizer test failed");
    $finish;
  end

endmodule
